[src/reb_pkg.sv]
package reb_pkg;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    localparam logic [CFG_IDX_W-1:0] CFG_MIN_POS       = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_POS       = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_WRAP_MODE     = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_FAST_THRESH   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_FAST_STEP     = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_BTN_DEBOUNCE  = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_ENC_DEBOUNCE  = 3'd6;
    localparam logic [CFG_IDX_W-1:0] CFG_LONG_PRESS    = 3'd7;

    localparam logic CMD_SAMPLE = 1'b0;
    localparam logic CMD_LOAD   = 1'b1;

    localparam logic [1:0] EV_NONE    = 2'd0;
    localparam logic [1:0] EV_PRESS   = 2'd1;
    localparam logic [1:0] EV_RELEASE = 2'd2;
    localparam logic [1:0] EV_LONG    = 2'd3;

    typedef struct packed {
        logic signed [15:0] min_pos;
        logic signed [15:0] max_pos;
        logic               wrap_mode;
        logic [15:0]        fast_threshold_ms;
        logic [7:0]         fast_step;
        logic [7:0]         btn_debounce_ms;
        logic [7:0]         enc_debounce_ms;
        logic [15:0]        long_press_ms;
    } t_cfg;

    typedef struct packed {
        logic        level;
        logic [1:0]  kind;
        logic [31:0] etime;
    } t_btn_evt;

endpackage

[src/reb_button.sv]
module reb_button (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_fire,
    input  logic              i_command,
    input  logic [31:0]       i_now_ms,
    input  logic              i_pin_button,
    input  reb_pkg::t_cfg     i_cfg,
    output reb_pkg::t_btn_evt o_evt
);

    logic        r_stable;
    logic        r_previous;
    logic        r_timing;
    logic [31:0] r_change_time;
    logic [31:0] r_press_time;

    logic        n_stable;
    logic        n_previous;
    logic        n_timing;
    logic [31:0] n_change_time;
    logic [31:0] n_press_time;

    logic [31:0] s_since_change;
    logic [31:0] s_since_press;
    logic        s_deb_done;
    logic        s_press;
    logic        s_long;
    logic [1:0]  s_kind;
    logic [31:0] s_etime;
    logic        s_sample;

    assign s_sample       = i_fire && (i_command == reb_pkg::CMD_SAMPLE);
    assign s_since_change = i_now_ms - r_change_time;
    assign s_since_press  = i_now_ms - r_press_time;
    // A change first seen in this transaction has zero elapsed time and cannot finish.
    assign s_deb_done     = r_timing && (s_since_change > {24'd0, i_cfg.btn_debounce_ms});

    always_comb begin
        n_stable      = r_stable;
        n_previous    = r_previous;
        n_timing      = r_timing;
        n_change_time = r_change_time;
        n_press_time  = r_press_time;
        s_kind        = reb_pkg::EV_NONE;
        s_etime       = 32'd0;
        s_press       = 1'b0;
        s_long        = 1'b0;
        if ((i_pin_button != r_stable) && !r_timing) begin
            n_change_time = i_now_ms;
            n_timing      = 1'b1;
        end
        if (s_deb_done) begin
            n_previous = r_stable;
            n_stable   = i_pin_button;
            n_timing   = 1'b0;
            if (!r_stable && i_pin_button) begin
                s_kind  = reb_pkg::EV_RELEASE;
                s_etime = s_since_press;
            end
            if (r_stable && !i_pin_button) begin
                s_press      = 1'b1;
                n_press_time = i_now_ms;
                s_kind       = reb_pkg::EV_PRESS;
                s_etime      = i_now_ms;
            end
        end
        s_long = !s_press && n_previous && !n_stable
                 && (s_since_press > {16'd0, i_cfg.long_press_ms});
        if (s_long) begin
            s_kind       = reb_pkg::EV_LONG;
            s_etime      = s_since_press;
            n_press_time = i_now_ms;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_stable      <= 1'b1;
            r_previous    <= 1'b1;
            r_timing      <= 1'b0;
            r_change_time <= 32'd0;
            r_press_time  <= 32'd0;
        end else if (s_sample) begin
            r_stable      <= n_stable;
            r_previous    <= n_previous;
            r_timing      <= n_timing;
            r_change_time <= n_change_time;
            r_press_time  <= n_press_time;
        end
    end

    assign o_evt.level = (i_command == reb_pkg::CMD_SAMPLE) ? n_stable : r_stable;
    assign o_evt.kind  = (i_command == reb_pkg::CMD_SAMPLE) ? s_kind : reb_pkg::EV_NONE;
    assign o_evt.etime = (i_command == reb_pkg::CMD_SAMPLE) ? s_etime : 32'd0;

endmodule

[src/reb_encoder.sv]
module reb_encoder (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_fire,
    input  logic               i_command,
    input  logic [31:0]        i_now_ms,
    input  logic               i_pin_a,
    input  logic               i_pin_b,
    input  logic signed [15:0] i_new_position,
    input  reb_pkg::t_cfg      i_cfg,
    output logic signed [15:0] o_position
);

    logic signed [15:0] r_position;
    logic               r_a_last;
    logic [31:0]        r_edge_time;

    logic signed [15:0] n_position;
    logic               n_a_last;
    logic [31:0]        n_edge_time;

    logic [31:0]        s_gap;
    logic               s_accept;
    logic signed [17:0] s_delta;
    logic signed [17:0] s_sum;
    logic signed [17:0] s_clamp_hi;
    logic signed [17:0] s_clamp_lo;
    logic signed [17:0] s_min;
    logic signed [17:0] s_max;

    assign s_gap    = i_now_ms - r_edge_time;
    assign s_accept = (i_pin_a != r_a_last) && (s_gap >= {24'd0, i_cfg.enc_debounce_ms});
    assign s_min    = {{2{i_cfg.min_pos[15]}}, i_cfg.min_pos};
    assign s_max    = {{2{i_cfg.max_pos[15]}}, i_cfg.max_pos};
    assign s_delta  = (s_gap < {16'd0, i_cfg.fast_threshold_ms})
                      ? $signed({10'd0, i_cfg.fast_step}) : 18'sd1;

    always_comb begin
        if (i_pin_b == i_pin_a) begin
            s_sum = {{2{r_position[15]}}, r_position} + s_delta;
        end else begin
            s_sum = {{2{r_position[15]}}, r_position} - s_delta;
        end
        s_clamp_hi = s_sum;
        if (s_sum > s_max) begin
            s_clamp_hi = i_cfg.wrap_mode ? s_min : s_max;
        end
        s_clamp_lo = s_clamp_hi;
        if (s_clamp_hi < s_min) begin
            s_clamp_lo = i_cfg.wrap_mode ? s_max : s_min;
        end
    end

    always_comb begin
        n_position  = r_position;
        n_a_last    = r_a_last;
        n_edge_time = r_edge_time;
        if (i_command == reb_pkg::CMD_LOAD) begin
            n_position = i_new_position;
        end else if (s_accept) begin
            n_a_last = i_pin_a;
            if (!i_pin_a) begin
                n_position  = s_clamp_lo[15:0];
                n_edge_time = i_now_ms;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_position  <= 16'sd0;
            r_a_last    <= 1'b0;
            r_edge_time <= 32'd0;
        end else if (i_fire) begin
            r_position  <= n_position;
            r_a_last    <= n_a_last;
            r_edge_time <= n_edge_time;
        end
    end

    assign o_position = n_position;

endmodule

[src/rotary_encoder_with_button_unit.sv]
// Rotary encoder with push button.
// Input channel (i_in_valid, o_in_stall): one transaction is either a pin
// sample (time stamp and A, B and button levels) or a position load.
// Output channel (o_out_valid, i_out_stall): exactly one transaction per input
// transaction, in order, carrying the position, the debounced button level
// and a press, release or long press event with its time.
// Configuration is written through i_cfg_we, i_cfg_index and i_cfg_data; the
// user must write it only while no transaction is in flight, which the block itself
// does not enforce. Writes take effect at the next clock edge. The accepting edge
// loads the input register, then the button and encoder logic writes the result
// register once it is free. Throughput is one transaction per cycle while the
// receiver does not stall, set by the single input register to result register path.
// A synchronous active low reset empties both registers, restores the
// configuration defaults and returns the button to released, position zero.
// When the receiver stalls, the result register holds; the input register
// still takes one more transaction, then o_in_stall rises until the result
// is taken.
module rotary_encoder_with_button_unit (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_in_valid,
    output logic                                o_in_stall,
    input  logic                                i_command,
    input  logic [31:0]                         i_now_ms,
    input  logic                                i_pin_a,
    input  logic                                i_pin_b,
    input  logic                                i_pin_button,
    input  logic signed [15:0]                  i_new_position,
    output logic                                o_out_valid,
    input  logic                                i_out_stall,
    output logic signed [15:0]                  o_position,
    output logic                                o_button_level,
    output logic [1:0]                          o_event_kind,
    output logic [31:0]                         o_event_time,
    input  logic                                i_cfg_we,
    input  logic [reb_pkg::CFG_IDX_W-1:0]       i_cfg_index,
    input  logic [reb_pkg::CFG_DATA_W-1:0]      i_cfg_data
);

    reb_pkg::t_cfg      r_cfg;

    logic               r_in_valid;
    logic               r_command;
    logic [31:0]        r_now_ms;
    logic               r_pin_a;
    logic               r_pin_b;
    logic               r_pin_button;
    logic signed [15:0] r_new_position;

    logic               r_out_valid;
    logic signed [15:0] r_position;
    reb_pkg::t_btn_evt  r_evt;

    logic               s_out_free;
    logic               s_fire;
    logic               s_in_take;
    logic signed [15:0] s_position;
    reb_pkg::t_btn_evt  s_evt;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.min_pos           <= 16'sd0;
            r_cfg.max_pos           <= 16'sd255;
            r_cfg.wrap_mode         <= 1'b0;
            r_cfg.fast_threshold_ms <= 16'd15;
            r_cfg.fast_step         <= 8'd10;
            r_cfg.btn_debounce_ms   <= 8'd10;
            r_cfg.enc_debounce_ms   <= 8'd4;
            r_cfg.long_press_ms     <= 16'd800;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                reb_pkg::CFG_MIN_POS:      r_cfg.min_pos           <= i_cfg_data;
                reb_pkg::CFG_MAX_POS:      r_cfg.max_pos           <= i_cfg_data;
                reb_pkg::CFG_WRAP_MODE:    r_cfg.wrap_mode         <= i_cfg_data[0];
                reb_pkg::CFG_FAST_THRESH:  r_cfg.fast_threshold_ms <= i_cfg_data;
                reb_pkg::CFG_FAST_STEP:    r_cfg.fast_step         <= i_cfg_data[7:0];
                reb_pkg::CFG_BTN_DEBOUNCE: r_cfg.btn_debounce_ms   <= i_cfg_data[7:0];
                reb_pkg::CFG_ENC_DEBOUNCE: r_cfg.enc_debounce_ms   <= i_cfg_data[7:0];
                reb_pkg::CFG_LONG_PRESS:   r_cfg.long_press_ms     <= i_cfg_data;
                default: ;
            endcase
        end
    end

    assign s_out_free = !r_out_valid || !i_out_stall;
    assign s_fire     = r_in_valid && s_out_free;
    assign s_in_take  = i_in_valid && !o_in_stall;
    assign o_in_stall = r_in_valid && !s_out_free;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (s_in_take) begin
            r_in_valid <= 1'b1;
        end else if (s_fire) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_in_take) begin
            r_command      <= i_command;
            r_now_ms       <= i_now_ms;
            r_pin_a        <= i_pin_a;
            r_pin_b        <= i_pin_b;
            r_pin_button   <= i_pin_button;
            r_new_position <= i_new_position;
        end
    end

    reb_button u_button (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_fire       (s_fire),
        .i_command    (r_command),
        .i_now_ms     (r_now_ms),
        .i_pin_button (r_pin_button),
        .i_cfg        (r_cfg),
        .o_evt        (s_evt)
    );

    reb_encoder u_encoder (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_fire         (s_fire),
        .i_command      (r_command),
        .i_now_ms       (r_now_ms),
        .i_pin_a        (r_pin_a),
        .i_pin_b        (r_pin_b),
        .i_new_position (r_new_position),
        .i_cfg          (r_cfg),
        .o_position     (s_position)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (s_out_free) begin
            r_out_valid <= s_fire;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_fire) begin
            r_position <= s_position;
            r_evt      <= s_evt;
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_position     = r_position;
    assign o_button_level = r_evt.level;
    assign o_event_kind   = r_evt.kind;
    assign o_event_time   = r_evt.etime;

endmodule

[src/reb_checker.sv]
module reb_checker (
    input logic                           i_clk,
    input logic                           i_rst_n,
    input logic                           i_in_valid,
    input logic                           o_in_stall,
    input logic                           i_command,
    input logic [31:0]                    i_now_ms,
    input logic                           i_pin_a,
    input logic                           i_pin_b,
    input logic                           i_pin_button,
    input logic signed [15:0]             i_new_position,
    input logic                           o_out_valid,
    input logic                           i_out_stall,
    input logic signed [15:0]             o_position,
    input logic                           o_button_level,
    input logic [1:0]                     o_event_kind,
    input logic [31:0]                    o_event_time,
    input logic                           i_cfg_we,
    input logic [reb_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input logic [reb_pkg::CFG_DATA_W-1:0] i_cfg_data
);

    a_stall_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall) |=> (o_out_valid && $stable(o_position)
            && $stable(o_event_kind) && $stable(o_event_time)))
        else $error("Stalled output transaction changed.");

    a_none_zero_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && (o_event_kind == reb_pkg::EV_NONE)) |-> (o_event_time == 32'd0))
        else $error("Event time set without an event.");

    a_level_matches: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && ((o_event_kind == reb_pkg::EV_PRESS)
            || (o_event_kind == reb_pkg::EV_LONG))) |-> !o_button_level)
        else $error("Press event with released button level.");

    a_release_level: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && (o_event_kind == reb_pkg::EV_RELEASE)) |-> o_button_level)
        else $error("Release event with pressed button level.");

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("Output valid right after reset.");

endmodule

bind rotary_encoder_with_button_unit reb_checker u_reb_checker (.*);

[sim/reb_result_checker.sv]
module reb_result_checker (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_in_valid,
    input  logic                           i_in_stall,
    input  logic                           i_command,
    input  logic [31:0]                    i_now_ms,
    input  logic                           i_pin_a,
    input  logic                           i_pin_b,
    input  logic                           i_pin_button,
    input  logic signed [15:0]             i_new_position,
    input  logic                           i_out_valid,
    input  logic                           i_out_stall,
    input  logic signed [15:0]             i_position,
    input  logic                           i_button_level,
    input  logic [1:0]                     i_event_kind,
    input  logic [31:0]                    i_event_time,
    input  logic                           i_cfg_we,
    input  logic [reb_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [reb_pkg::CFG_DATA_W-1:0] i_cfg_data,
    output int                             o_fail_count,
    output int                             o_pending
);

    localparam int MAX_REPORTS = 10;

    typedef struct packed {
        logic signed [15:0] position;
        logic               level;
        logic [1:0]         kind;
        logic [31:0]        etime;
    } t_knob_state;

    reb_pkg::t_cfg      cfg;
    logic signed [15:0] pos_q;
    logic               btn_stable;
    logic               btn_prev;
    logic               btn_timing;
    logic [31:0]        btn_change_ms;
    logic [31:0]        btn_press_ms;
    logic               a_last;
    logic [31:0]        edge_ms;

    t_knob_state        knob_states_q[$];
    t_knob_state        want;
    int                 fails = 0;

    initial begin
        o_fail_count = 0;
        o_pending = 0;
    end

    function automatic t_knob_state advance_knob(input logic cmd, input logic [31:0] stamp,
                                                 input logic a, input logic b,
                                                 input logic btn,
                                                 input logic signed [15:0] load_pos);
        t_knob_state r;
        logic [31:0] elapsed;
        logic [31:0] held;
        logic [31:0] gap;
        int          step;
        int          sum;
        int          lim_lo;
        int          lim_hi;
        r.kind = reb_pkg::EV_NONE;
        r.etime = '0;
        if (cmd == reb_pkg::CMD_LOAD) begin
            pos_q = load_pos;
        end else begin
            if (btn != btn_stable && !btn_timing) begin
                btn_change_ms = stamp;
                btn_timing = 1'b1;
            end
            elapsed = stamp - btn_change_ms;
            if (btn_timing && elapsed > 32'(cfg.btn_debounce_ms)) begin
                btn_prev = btn_stable;
                btn_stable = btn;
                btn_timing = 1'b0;
                if (!btn_prev && btn_stable) begin
                    r.kind = reb_pkg::EV_RELEASE;
                    r.etime = stamp - btn_press_ms;
                end
                if (btn_prev && !btn_stable) begin
                    btn_press_ms = stamp;
                    r.kind = reb_pkg::EV_PRESS;
                    r.etime = stamp;
                end
            end
            held = stamp - btn_press_ms;
            if (btn_prev && !btn_stable && held > 32'(cfg.long_press_ms)) begin
                r.kind = reb_pkg::EV_LONG;
                r.etime = held;
                btn_press_ms = stamp;
            end
            if (a != a_last) begin
                gap = stamp - edge_ms;
                if (gap >= 32'(cfg.enc_debounce_ms)) begin
                    if (!a) begin
                        step = (gap < 32'(cfg.fast_threshold_ms)) ? int'(cfg.fast_step) : 1;
                        lim_lo = int'($signed(cfg.min_pos));
                        lim_hi = int'($signed(cfg.max_pos));
                        sum = (b == a) ? int'(pos_q) + step : int'(pos_q) - step;
                        if (sum > lim_hi) sum = cfg.wrap_mode ? lim_lo : lim_hi;
                        if (sum < lim_lo) sum = cfg.wrap_mode ? lim_hi : lim_lo;
                        pos_q = 16'(sum);
                        edge_ms = stamp;
                    end
                    a_last = a;
                end
            end
        end
        r.position = pos_q;
        r.level = btn_stable;
        return r;
    endfunction

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            cfg.min_pos = 16'sd0;
            cfg.max_pos = 16'sd255;
            cfg.wrap_mode = 1'b0;
            cfg.fast_threshold_ms = 16'd15;
            cfg.fast_step = 8'd10;
            cfg.btn_debounce_ms = 8'd10;
            cfg.enc_debounce_ms = 8'd4;
            cfg.long_press_ms = 16'd800;
            pos_q = '0;
            btn_stable = 1'b1;
            btn_prev = 1'b1;
            btn_timing = 1'b0;
            btn_change_ms = '0;
            btn_press_ms = '0;
            a_last = 1'b0;
            edge_ms = '0;
            knob_states_q.delete();
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_index)
                    reb_pkg::CFG_MIN_POS:      cfg.min_pos = i_cfg_data;
                    reb_pkg::CFG_MAX_POS:      cfg.max_pos = i_cfg_data;
                    reb_pkg::CFG_WRAP_MODE:    cfg.wrap_mode = i_cfg_data[0];
                    reb_pkg::CFG_FAST_THRESH:  cfg.fast_threshold_ms = i_cfg_data;
                    reb_pkg::CFG_FAST_STEP:    cfg.fast_step = i_cfg_data[7:0];
                    reb_pkg::CFG_BTN_DEBOUNCE: cfg.btn_debounce_ms = i_cfg_data[7:0];
                    reb_pkg::CFG_ENC_DEBOUNCE: cfg.enc_debounce_ms = i_cfg_data[7:0];
                    reb_pkg::CFG_LONG_PRESS:   cfg.long_press_ms = i_cfg_data;
                    default: ;
                endcase
            end
            if (i_out_valid && !i_out_stall) begin
                if (knob_states_q.size() == 0) begin
                    fails++;
                    if (fails <= MAX_REPORTS)
                        $display("%0t: unexpected transaction: position %0d level %0b",
                                 $realtime, i_position, i_button_level,
                                 " kind %0d time %0d", i_event_kind, i_event_time);
                end else begin
                    want = knob_states_q.pop_front();
                    if (want.position !== i_position || want.level !== i_button_level ||
                        want.kind !== i_event_kind || want.etime !== i_event_time) begin
                        fails++;
                        if (fails <= MAX_REPORTS)
                            $display("%0t: mismatch: expected position %0d level %0b",
                                     $realtime, $signed(want.position), want.level,
                                     " kind %0d time %0d", want.kind, want.etime,
                                     ", got position %0d level %0b", i_position,
                                     i_button_level, " kind %0d time %0d", i_event_kind,
                                     i_event_time);
                    end
                end
            end
            if (i_in_valid && !i_in_stall)
                knob_states_q.push_back(advance_knob(i_command, i_now_ms, i_pin_a, i_pin_b,
                                                     i_pin_button, i_new_position));
        end
        o_fail_count <= fails;
        o_pending <= knob_states_q.size();
    end

endmodule

[sim/testbench.sv]
module testbench;

    localparam int CYCLE_LIMIT = 400000;
    localparam int ITEMS_PER_PHASE = 85;

    logic                           clk = 1'b0;
    logic                           rst_n = 1'b0;
    logic                           in_valid = 1'b0;
    logic                           in_stall;
    logic                           command = reb_pkg::CMD_SAMPLE;
    logic [31:0]                    now_ms = '0;
    logic                           pin_a = 1'b0;
    logic                           pin_b = 1'b0;
    logic                           pin_button = 1'b1;
    logic signed [15:0]             new_position = '0;
    logic                           out_valid;
    logic                           out_stall = 1'b0;
    logic signed [15:0]             position;
    logic                           button_level;
    logic [1:0]                     event_kind;
    logic [31:0]                    event_time;
    logic                           cfg_we = 1'b0;
    logic [reb_pkg::CFG_IDX_W-1:0]  cfg_index = reb_pkg::CFG_MIN_POS;
    logic [reb_pkg::CFG_DATA_W-1:0] cfg_data = '0;
    int                             fail_count;
    int                             pending;

    logic                           idle_enable = 1'b1;
    logic                           stall_enable = 1'b1;
    int                             stall_left = 0;
    int                             cycle_count = 0;
    logic [31:0]                    clock_ms = '0;
    logic                           enc_level = 1'b0;
    logic                           spin_dir = 1'b0;
    logic                           btn_intent = 1'b1;
    logic signed [15:0]             lim_lo = 16'sd0;
    logic signed [15:0]             lim_hi = 16'sd255;

    always #4 clk = ~clk;

    rotary_encoder_with_button_unit uut (
        .i_clk          (clk),
        .i_rst_n        (rst_n),
        .i_in_valid     (in_valid),
        .o_in_stall     (in_stall),
        .i_command      (command),
        .i_now_ms       (now_ms),
        .i_pin_a        (pin_a),
        .i_pin_b        (pin_b),
        .i_pin_button   (pin_button),
        .i_new_position (new_position),
        .o_out_valid    (out_valid),
        .i_out_stall    (out_stall),
        .o_position     (position),
        .o_button_level (button_level),
        .o_event_kind   (event_kind),
        .o_event_time   (event_time),
        .i_cfg_we       (cfg_we),
        .i_cfg_index    (cfg_index),
        .i_cfg_data     (cfg_data)
    );

    reb_result_checker u_result_checker (
        .i_clk          (clk),
        .i_rst_n        (rst_n),
        .i_in_valid     (in_valid),
        .i_in_stall     (in_stall),
        .i_command      (command),
        .i_now_ms       (now_ms),
        .i_pin_a        (pin_a),
        .i_pin_b        (pin_b),
        .i_pin_button   (pin_button),
        .i_new_position (new_position),
        .i_out_valid    (out_valid),
        .i_out_stall    (out_stall),
        .i_position     (position),
        .i_button_level (button_level),
        .i_event_kind   (event_kind),
        .i_event_time   (event_time),
        .i_cfg_we       (cfg_we),
        .i_cfg_index    (cfg_index),
        .i_cfg_data     (cfg_data),
        .o_fail_count   (fail_count),
        .o_pending      (pending)
    );

    always @(posedge clk) begin
        if (stall_left > 0) begin
            stall_left <= stall_left - 1;
            out_stall <= 1'b1;
        end else if (stall_enable && $urandom_range(0, 9) == 0) begin
            stall_left <= $urandom_range(0, 16);
            out_stall <= 1'b1;
        end else begin
            out_stall <= 1'b0;
        end
    end

    initial begin
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge clk);
            cycle_count++;
        end
        $display("TEST FAILED");
        $finish;
    end

    task automatic send_item(input logic cmd, input logic [31:0] stamp, input logic a,
                             input logic b, input logic btn,
                             input logic signed [15:0] load_pos);
        int gap_len;
        if (idle_enable && $urandom_range(0, 5) == 0) begin
            gap_len = $urandom_range(1, 17);
            in_valid <= 1'b0;
            repeat (gap_len) @(posedge clk);
        end
        in_valid <= 1'b1;
        command <= cmd;
        now_ms <= stamp;
        pin_a <= a;
        pin_b <= b;
        pin_button <= btn;
        new_position <= load_pos;
        @(posedge clk);
        while (in_stall) @(posedge clk);
    endtask

    task automatic sample(input logic [31:0] stamp, input logic a, input logic b,
                          input logic btn);
        clock_ms = stamp;
        send_item(reb_pkg::CMD_SAMPLE, stamp, a, b, btn, 16'($urandom()));
    endtask

    task automatic load(input logic signed [15:0] load_pos);
        send_item(reb_pkg::CMD_LOAD, $urandom(), 1'($urandom()), 1'($urandom()),
                  1'($urandom()), load_pos);
    endtask

    task automatic wait_for_results();
        in_valid <= 1'b0;
        do @(posedge clk); while (pending != 0);
    endtask

    task automatic write_reg(input logic [reb_pkg::CFG_IDX_W-1:0] idx,
                             input logic [reb_pkg::CFG_DATA_W-1:0] value);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value;
        @(posedge clk);
    endtask

    task automatic write_settings(input logic signed [15:0] lo, input logic signed [15:0] hi,
                                  input logic wrap, input logic [15:0] thresh,
                                  input logic [7:0] step, input logic [7:0] btn_db,
                                  input logic [7:0] enc_db, input logic [15:0] long_ms);
        write_reg(reb_pkg::CFG_MIN_POS, lo);
        write_reg(reb_pkg::CFG_MAX_POS, hi);
        write_reg(reb_pkg::CFG_WRAP_MODE, 16'(wrap));
        write_reg(reb_pkg::CFG_FAST_THRESH, thresh);
        write_reg(reb_pkg::CFG_FAST_STEP, 16'(step));
        write_reg(reb_pkg::CFG_BTN_DEBOUNCE, 16'(btn_db));
        write_reg(reb_pkg::CFG_ENC_DEBOUNCE, 16'(enc_db));
        write_reg(reb_pkg::CFG_LONG_PRESS, long_ms);
        cfg_we <= 1'b0;
        lim_lo = lo;
        lim_hi = hi;
    endtask

    task automatic send_random_item();
        int                 pick;
        logic signed [15:0] load_pos;
        pick = $urandom_range(0, 99);
        if (pick < 5) begin
            case ($urandom_range(0, 5))
                0: load_pos = 16'sh7FFF;
                1: load_pos = 16'sh8000;
                2: load_pos = lim_lo + 16'($urandom_range(0, 3));
                3: load_pos = lim_hi - 16'($urandom_range(0, 3));
                default: load_pos = 16'($urandom());
            endcase
            load(load_pos);
        end else begin
            pick = $urandom_range(0, 99);
            if (pick < 35) clock_ms += $urandom_range(0, 3);
            else if (pick < 75) clock_ms += $urandom_range(4, 20);
            else if (pick < 93) clock_ms += $urandom_range(21, 400);
            else if (pick < 97) clock_ms += $urandom_range(401, 70000);
            else if (pick < 99) clock_ms = $urandom();
            else clock_ms = 32'hFFFF_FF00 + $urandom_range(0, 255);
            if ($urandom_range(0, 9) < 6) enc_level = ~enc_level;
            if ($urandom_range(0, 19) == 0) spin_dir = ~spin_dir;
            if ($urandom_range(0, 11) == 0) btn_intent = ~btn_intent;
            sample(clock_ms, enc_level, spin_dir ^ ($urandom_range(0, 9) == 0),
                   btn_intent ^ ($urandom_range(0, 5) == 0));
        end
    endtask

    task automatic send_random_items(input int count);
        repeat (count) send_random_item();
    endtask

    initial begin
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        load(16'sh7FFF);
        load(16'sh8000);
        load(16'sd0);
        sample(32'd100, 1'b1, 1'b0, 1'b1);
        sample(32'd101, 1'b0, 1'b0, 1'b1);
        sample(32'd102, 1'b1, 1'b0, 1'b1);
        sample(32'd103, 1'b0, 1'b1, 1'b1);
        sample(32'd106, 1'b0, 1'b1, 1'b1);
        load(16'sd250);
        sample(32'd107, 1'b1, 1'b0, 1'b1);
        sample(32'd111, 1'b0, 1'b0, 1'b1);
        sample(32'd200, 1'b0, 1'b0, 1'b0);
        sample(32'd211, 1'b0, 1'b0, 1'b0);
        sample(32'd1100, 1'b0, 1'b0, 1'b0);
        sample(32'd1101, 1'b0, 1'b0, 1'b1);
        sample(32'd1105, 1'b0, 1'b0, 1'b0);
        sample(32'd1112, 1'b0, 1'b0, 1'b0);
        sample(32'd2000, 1'b0, 1'b0, 1'b0);
        sample(32'd2001, 1'b0, 1'b0, 1'b1);
        sample(32'd2012, 1'b0, 1'b0, 1'b1);
        sample(32'd2100, 1'b0, 1'b0, 1'b0);
        sample(32'd2110, 1'b0, 1'b0, 1'b0);
        sample(32'd2111, 1'b0, 1'b0, 1'b0);
        send_random_items(ITEMS_PER_PHASE);

        wait_for_results();
        write_settings(16'sh8000, 16'sh7FFF, 1'b1, 16'hFFFF, 8'd255, 8'd0, 8'd0, 16'd0);
        load(16'sh7FFF);
        sample(clock_ms + 1, 1'b1, 1'b0, 1'b1);
        sample(clock_ms + 1, 1'b0, 1'b0, 1'b1);
        send_random_items(ITEMS_PER_PHASE);

        wait_for_results();
        write_settings(16'sd100, -16'sd100, 1'b0, 16'd0, 8'd0, 8'd255, 8'd255, 16'hFFFF);
        send_random_items(ITEMS_PER_PHASE);

        wait_for_results();
        write_settings(16'sh7FFF, 16'sh8000, 1'b1, 16'd40, 8'd7, 8'd3, 8'd2, 16'd50);
        send_random_items(ITEMS_PER_PHASE);

        repeat (4) begin
            wait_for_results();
            lim_lo = 16'($urandom_range(0, 600)) - 16'sd300;
            write_settings(lim_lo, lim_lo + 16'($urandom_range(0, 400)),
                           1'($urandom_range(0, 1)), 16'($urandom_range(0, 60)),
                           8'($urandom_range(0, 255)), 8'($urandom_range(0, 20)),
                           8'($urandom_range(0, 10)), 16'($urandom_range(0, 400)));
            send_random_items(ITEMS_PER_PHASE);
        end

        idle_enable = 1'b0;
        stall_enable = 1'b0;
        wait_for_results();
        write_settings(-16'sd5, 16'sd5, 1'b1, 16'd30, 8'd3, 8'd2, 8'd1, 16'd100);
        send_random_items(ITEMS_PER_PHASE);

        wait_for_results();
        repeat (8) @(posedge clk);
        if (fail_count == 0 && pending == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule

[files.f]
src/reb_pkg.sv
src/reb_button.sv
src/reb_encoder.sv
src/rotary_encoder_with_button_unit.sv
src/reb_checker.sv
sim/reb_result_checker.sv
sim/testbench.sv
